[hw/rtl/sbpo_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere-box push offset: shared types and constants
// Widths of the distance, root and divide datapaths, and the register map.
// ----------------------------------------------------------------------------
package sbpo_pkg;

   localparam int MAG_W  = 32;   // |center - clamp| per axis
   localparam int SUM_W  = 66;   // sum of three squares
   localparam int ROOT_W = 33;   // floor root of the sum
   localparam int REM_W  = 35;   // root remainder
   localparam int PROD_W = 65;   // |d| * |r - m|
   localparam int QUO_W  = 33;   // quotient bits, one per divide stage

   localparam logic [2:0] REG_LOW_X  = 3'd0;
   localparam logic [2:0] REG_LOW_Y  = 3'd1;
   localparam logic [2:0] REG_LOW_Z  = 3'd2;
   localparam logic [2:0] REG_HIGH_X = 3'd3;
   localparam logic [2:0] REG_HIGH_Y = 3'd4;
   localparam logic [2:0] REG_HIGH_Z = 3'd5;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            dneg;
      logic [2:0]            cz;
      logic                  in_box;
      logic [30:0]           radius;
   } item_type;

   typedef struct packed {
      logic       in_box;
      logic [2:0] cz;
      logic [2:0] neg;
      logic       mz;
   } tag_type;

endpackage

[hw/rtl/sphere_box_push_offset.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere-box push offset
// Clamp, squared distance, pipelined root, multiply and divide per axis.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle unless the response stalls; the 33-stage root
// and the 33-stage dividers each produce one bit per stage, so the pipeline
// depth sets latency. A stalled response holds the whole pipeline in place.
// Reset clears the box registers to zero and empties the pipeline.
module sphere_box_push_offset #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic        [30:0] req_radius,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_offset_x,
   output logic signed [31:0] rsp_offset_y,
   output logic signed [31:0] rsp_offset_z,
   output logic               rsp_center_inside,
   output logic               rsp_zero_distance,
   input  logic               csr_write,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_wdata
);

   localparam int MW  = sbpo_pkg::MAG_W;
   localparam int RTW = sbpo_pkg::ROOT_W;
   localparam int QW  = sbpo_pkg::QUO_W;
   localparam int PW  = sbpo_pkg::PROD_W;
   localparam logic [31:0] OneVal = 32'd1 << FRAC_BITS;
   localparam logic [31:0] NegOneVal = -OneVal;

   logic en;

   // box registers
   logic signed [31:0] lo_ff [3];
   logic signed [31:0] hi_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            lo_ff[k] <= '0;
            hi_ff[k] <= '0;
         end
      end else if (csr_write) begin
         case (csr_index)
            sbpo_pkg::REG_LOW_X:  lo_ff[0] <= csr_wdata;
            sbpo_pkg::REG_LOW_Y:  lo_ff[1] <= csr_wdata;
            sbpo_pkg::REG_LOW_Z:  lo_ff[2] <= csr_wdata;
            sbpo_pkg::REG_HIGH_X: hi_ff[0] <= csr_wdata;
            sbpo_pkg::REG_HIGH_Y: hi_ff[1] <= csr_wdata;
            sbpo_pkg::REG_HIGH_Z: hi_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: clamp and distance
   logic signed [31:0] c [3];
   sbpo_pkg::item_type s1_in;
   sbpo_pkg::item_type s1_ff;
   logic               s1_v_ff;

   assign c[0] = req_center_x;
   assign c[1] = req_center_y;
   assign c[2] = req_center_z;

   always_comb begin
      logic signed [31:0] p;
      logic signed [32:0] d;
      logic signed [32:0] nd;
      logic               ins;
      ins = 1'b1;
      s1_in.radius = req_radius;
      for (int k = 0; k < 3; k++) begin
         if (!(c[k] > lo_ff[k] && c[k] < hi_ff[k])) ins = 1'b0;
         if (c[k] < lo_ff[k]) p = lo_ff[k];
         else if (c[k] > hi_ff[k]) p = hi_ff[k];
         else p = c[k];
         d  = {c[k][31], c[k]} - {p[31], p};
         nd = -d;
         s1_in.mag[k]  = d[32] ? nd[MW-1:0] : d[MW-1:0];
         s1_in.dneg[k] = d[32];
         s1_in.cz[k]   = c[k] == 32'sd0;
      end
      s1_in.in_box = ins;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) s1_ff <= s1_in;
   end

   // stage 2: squares
   logic [63:0]        sq_ff [3];
   sbpo_pkg::item_type s2_ff;
   logic               s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= {32'd0, s1_ff.mag[k]} * {32'd0, s1_ff.mag[k]};
         end
         s2_ff <= s1_ff;
      end
   end

   // stage 3: sum of squares
   logic [sbpo_pkg::SUM_W-1:0] sum_ff;
   sbpo_pkg::item_type         s3_ff;
   logic                       s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
         s3_ff  <= s2_ff;
      end
   end

   // root
   logic               rt_v;
   logic [RTW-1:0]     rt_m;
   sbpo_pkg::item_type rt_item;

   sbpo_root u_root (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_v     (s3_v_ff),
      .in_sum   (sum_ff),
      .in_item  (s3_ff),
      .out_v    (rt_v),
      .out_root (rt_m),
      .out_item (rt_item)
   );

   // stage P1: r - m
   logic signed [34:0] rm;
   logic signed [34:0] nrm;
   logic               p1_v_ff;
   sbpo_pkg::item_type p1_ff;
   logic [RTW-1:0]     p1_m_ff;
   logic [RTW-1:0]     p1_rmag_ff;
   logic               p1_rneg_ff;

   assign rm  = $signed({4'd0, rt_item.radius}) - $signed({2'd0, rt_m});
   assign nrm = -rm;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff <= rt_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff      <= rt_item;
         p1_m_ff    <= rt_m;
         p1_rneg_ff <= rm[34];
         p1_rmag_ff <= rm[34] ? nrm[RTW-1:0] : rm[RTW-1:0];
      end
   end

   // stage P2: products
   logic [PW-1:0]     prod_ff [3];
   logic [RTW-1:0]    p2_m_ff;
   sbpo_pkg::tag_type p2_tag_ff;
   logic              p2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_v_ff <= 1'b0;
      end else if (en) begin
         p2_v_ff <= p1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k] <= {33'd0, p1_ff.mag[k]} * {32'd0, p1_rmag_ff};
         end
         p2_m_ff          <= p1_m_ff;
         p2_tag_ff.in_box <= p1_ff.in_box;
         p2_tag_ff.cz     <= p1_ff.cz;
         p2_tag_ff.neg    <= p1_ff.dneg ^ {3{p1_rneg_ff}};
         p2_tag_ff.mz     <= p1_m_ff == '0;
      end
   end

   // dividers, tags travel alongside
   logic [QW-1:0]     quo [3];
   logic              dv_v_ff   [QW];
   sbpo_pkg::tag_type dv_tag_ff [QW];

   for (genvar k = 0; k < 3; k++) begin : g_div
      sbpo_div u_div (
         .clock   (clock),
         .en      (en),
         .in_num  (prod_ff[k]),
         .in_den  (p2_m_ff),
         .out_quo (quo[k])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < QW; j++) dv_v_ff[j] <= 1'b0;
      end else if (en) begin
         dv_v_ff[0] <= p2_v_ff;
         for (int j = 1; j < QW; j++) dv_v_ff[j] <= dv_v_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_tag_ff[0] <= p2_tag_ff;
         for (int j = 1; j < QW; j++) dv_tag_ff[j] <= dv_tag_ff[j-1];
      end
   end

   // output stage: saturate and select
   sbpo_pkg::tag_type fin_tag;
   logic [31:0]       off_in [3];
   logic              out_v_ff;
   logic [31:0]       off_ff [3];
   logic              inside_ff;
   logic              zero_ff;

   assign fin_tag = dv_tag_ff[QW-1];

   always_comb begin
      logic [QW-1:0] nq;
      for (int k = 0; k < 3; k++) begin
         nq = -quo[k];
         if (fin_tag.in_box) begin
            off_in[k] = fin_tag.cz[k] ? NegOneVal : OneVal;
         end else if (fin_tag.mz) begin
            off_in[k] = '0;
         end else if (fin_tag.neg[k] && quo[k] != '0) begin
            off_in[k] = (quo[k] > QW'(33'h0_8000_0000)) ? 32'h8000_0000 : nq[31:0];
         end else begin
            off_in[k] = (quo[k] > QW'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : quo[k][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= dv_v_ff[QW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) off_ff[k] <= off_in[k];
         inside_ff <= fin_tag.in_box;
         zero_ff   <= !fin_tag.in_box && fin_tag.mz;
      end
   end

   // advance everything when the response register is free or drained
   assign en        = !out_v_ff || rsp_ready;
   assign req_ready = en;

   assign rsp_valid         = out_v_ff;
   assign rsp_offset_x      = off_ff[0];
   assign rsp_offset_y      = off_ff[1];
   assign rsp_offset_z      = off_ff[2];
   assign rsp_center_inside = inside_ff;
   assign rsp_zero_distance = zero_ff;

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_center_inside && rsp_zero_distance))
      else $error("inside and zero-distance flags both set");

   a_zero_offsets: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_distance |->
         rsp_offset_x == 32'sd0 && rsp_offset_y == 32'sd0 && rsp_offset_z == 32'sd0)
      else $error("zero-distance beat with nonzero offset");

   a_inside_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_center_inside |->
         (rsp_offset_x == OneVal || rsp_offset_x == NegOneVal) &&
         (rsp_offset_y == OneVal || rsp_offset_y == NegOneVal))
      else $error("inside beat offset is not unit");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s1_v_ff) && $stable(p2_v_ff) && $stable(out_v_ff))
      else $error("pipeline moved while stalled");

endmodule

[hw/rtl/sbpo_root.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere-box push offset: pipelined square root
// Digit-by-digit floor root, one result bit per register stage.
// ----------------------------------------------------------------------------
module sbpo_root (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_v,
   input  logic [sbpo_pkg::SUM_W-1:0]    in_sum,
   input  sbpo_pkg::item_type            in_item,
   output logic                          out_v,
   output logic [sbpo_pkg::ROOT_W-1:0]   out_root,
   output sbpo_pkg::item_type            out_item
);

   localparam int NS  = sbpo_pkg::ROOT_W;
   localparam int RMW = sbpo_pkg::REM_W;
   localparam int RTW = sbpo_pkg::ROOT_W;
   localparam int SW  = sbpo_pkg::SUM_W;

   logic                 v_ff    [NS];
   logic [RMW-1:0]       rem_ff  [NS];
   logic [RTW-1:0]       root_ff [NS];
   logic [SW-1:0]        rad_ff  [NS];
   sbpo_pkg::item_type   item_ff [NS];

   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic               prev_v;
      logic [RMW-1:0]     prev_rem;
      logic [RTW-1:0]     prev_root;
      logic [SW-1:0]      prev_rad;
      sbpo_pkg::item_type prev_item;
      logic [RMW+1:0]     rs;
      logic [RMW+1:0]     trial;
      logic [RMW+1:0]     diff;
      logic               take;

      if (i == 0) begin : g_first
         assign prev_v    = in_v;
         assign prev_rem  = '0;
         assign prev_root = '0;
         assign prev_rad  = in_sum;
         assign prev_item = in_item;
      end else begin : g_next
         assign prev_v    = v_ff[i-1];
         assign prev_rem  = rem_ff[i-1];
         assign prev_root = root_ff[i-1];
         assign prev_rad  = rad_ff[i-1];
         assign prev_item = item_ff[i-1];
      end

      assign rs    = {prev_rem, prev_rad[SW-1 -: 2]};
      assign trial = {{(RMW-RTW){1'b0}}, prev_root, 2'b01};
      assign take  = rs >= trial;
      assign diff  = rs - trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else if (en) begin
            v_ff[i] <= prev_v;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i]  <= take ? diff[RMW-1:0] : rs[RMW-1:0];
            root_ff[i] <= {prev_root[RTW-2:0], take};
            rad_ff[i]  <= {prev_rad[SW-3:0], 2'b00};
            item_ff[i] <= prev_item;
         end
      end
   end

   assign out_v    = v_ff[NS-1];
   assign out_root = root_ff[NS-1];
   assign out_item = item_ff[NS-1];

endmodule

[hw/rtl/sbpo_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere-box push offset: pipelined divider
// Restoring unsigned division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module sbpo_div (
   input  logic                          clock,
   input  logic                          en,
   input  logic [sbpo_pkg::PROD_W-1:0]   in_num,
   input  logic [sbpo_pkg::ROOT_W-1:0]   in_den,
   output logic [sbpo_pkg::QUO_W-1:0]    out_quo
);

   localparam int NS = sbpo_pkg::QUO_W;
   localparam int DW = sbpo_pkg::ROOT_W;
   localparam int PW = sbpo_pkg::PROD_W;

   logic [DW-1:0] rem_ff [NS];
   logic [NS-1:0] low_ff [NS];
   logic [NS-1:0] quo_ff [NS];
   logic [DW-1:0] den_ff [NS];

   for (genvar i = 0; i < NS; i++) begin : g_stage
      logic [DW-1:0] prev_rem;
      logic [NS-1:0] prev_low;
      logic [NS-1:0] prev_quo;
      logic [DW-1:0] prev_den;
      logic [DW:0]   rs;
      logic [DW:0]   diff;
      logic          take;

      if (i == 0) begin : g_first
         assign prev_rem = {{(DW-PW+NS){1'b0}}, in_num[PW-1:NS]};
         assign prev_low = in_num[NS-1:0];
         assign prev_quo = '0;
         assign prev_den = in_den;
      end else begin : g_next
         assign prev_rem = rem_ff[i-1];
         assign prev_low = low_ff[i-1];
         assign prev_quo = quo_ff[i-1];
         assign prev_den = den_ff[i-1];
      end

      assign rs   = {prev_rem, prev_low[NS-1]};
      assign take = rs >= {1'b0, prev_den};
      assign diff = rs - {1'b0, prev_den};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= take ? diff[DW-1:0] : rs[DW-1:0];
            low_ff[i] <= {prev_low[NS-2:0], 1'b0};
            quo_ff[i] <= {prev_quo[NS-2:0], take};
            den_ff[i] <= prev_den;
         end
      end
   end

   assign out_quo = quo_ff[NS-1];

endmodule

[tb/sv/tb_sphere_box_push_offset.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sphere-box push offset testbench
// Drives spheres against a series of box settings (reset, directed, full range,
// inverted and random boxes), idling both channels at random in most phases,
// predicts each push offset in exact arithmetic and checks every response beat.
// ----------------------------------------------------------------------------
module tb_sphere_box_push_offset;

   localparam int FRAC       = 16;
   localparam int IDLE_LIMIT = 4000;
   localparam int DRAIN_WAIT = 120;

   typedef struct {
      logic signed [31:0] cx, cy, cz;
      logic        [30:0] r;
   } sphere_type;

   typedef struct {
      logic [31:0] ox, oy, oz;
      logic        in_box, zdist;
   } push_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_center_x = '0, req_center_y = '0, req_center_z = '0;
   logic [30:0] req_radius = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_offset_x, rsp_offset_y, rsp_offset_z;
   logic rsp_center_inside, rsp_zero_distance;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   sphere_box_push_offset #(.FRAC_BITS(FRAC)) dut (.*);

   always #4 clock = ~clock;

   logic signed [31:0] box_lo [3];
   logic signed [31:0] box_hi [3];
   sphere_type sphere_q[$];
   push_type   push_q[$];
   int idle_mode = 0;
   int errors = 0;
   int idle_cycles = 0;
   logic req_fire = 1'b0;

   function automatic push_type predict_push(sphere_type s);
      logic signed [63:0] c [3];
      logic signed [63:0] d [3];
      logic signed [63:0] lo, hi, p, rm;
      logic [63:0] mag [3];
      logic [63:0] root, t, rmag;
      logic [127:0] sum, q;
      logic [31:0] o [3];
      bit in_box, neg;
      push_type e;
      c[0] = s.cx;
      c[1] = s.cy;
      c[2] = s.cz;
      sum = '0;
      in_box = 1;
      for (int k = 0; k < 3; k++) begin
         lo = box_lo[k];
         hi = box_hi[k];
         if (!(c[k] > lo && c[k] < hi)) in_box = 0;
         if (c[k] < lo) p = lo;
         else if (c[k] > hi) p = hi;
         else p = c[k];
         d[k] = c[k] - p;
         mag[k] = d[k] < 0 ? -d[k] : d[k];
         sum = sum + {64'd0, mag[k]} * {64'd0, mag[k]};
      end
      e.in_box = in_box;
      e.zdist = 0;
      if (in_box) begin
         for (int k = 0; k < 3; k++)
            o[k] = (c[k] == 0) ? -(32'sd1 <<< FRAC) : (32'sd1 <<< FRAC);
      end else begin
         root = '0;
         for (int b = 34; b >= 0; b--) begin
            t = root | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= sum) root = t;
         end
         if (root == 0) begin
            e.zdist = 1;
            for (int k = 0; k < 3; k++) o[k] = '0;
         end else begin
            rm = $signed({33'd0, s.r}) - $signed(root);
            rmag = rm < 0 ? -rm : rm;
            for (int k = 0; k < 3; k++) begin
               neg = (d[k] < 0) != (rm < 0);
               q = ({64'd0, mag[k]} * {64'd0, rmag}) / {64'd0, root};
               if (neg && q != 0)
                  o[k] = (q > 128'h8000_0000) ? 32'h8000_0000 : -q[31:0];
               else
                  o[k] = (q > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
            end
         end
      end
      e.ox = o[0];
      e.oy = o[1];
      e.oz = o[2];
      return e;
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_fire) begin
            // hold
         end else if (sphere_q.size() > 0 &&
                      !(idle_mode == 0 && $urandom_range(0, 99) < 21) &&
                      !(idle_mode == 1 && $urandom_range(0, 99) < 52)) begin
            sphere_type s;
            s = sphere_q.pop_front();
            req_center_x <= s.cx;
            req_center_y <= s.cy;
            req_center_z <= s.cz;
            req_radius <= s.r;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
         case (idle_mode)
            0: rsp_ready <= $urandom_range(0, 99) >= 52;
            1: rsp_ready <= $urandom_range(0, 99) >= 21;
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) begin
            sphere_type s;
            s.cx = req_center_x;
            s.cy = req_center_y;
            s.cz = req_center_z;
            s.r = req_radius;
            push_q.push_back(predict_push(s));
         end
         if (rsp_valid && rsp_ready) begin
            if (push_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected response beat");
            end else begin
               push_type e;
               e = push_q.pop_front();
               if (e.ox !== rsp_offset_x || e.oy !== rsp_offset_y ||
                   e.oz !== rsp_offset_z || e.in_box !== rsp_center_inside ||
                   e.zdist !== rsp_zero_distance) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch exp %h %h %h %b %b got %h %h %h %b %b",
                              e.ox, e.oy, e.oz, e.in_box, e.zdist, rsp_offset_x,
                              rsp_offset_y, rsp_offset_z, rsp_center_inside,
                              rsp_zero_distance);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic write_box(input logic [2:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx < 3) box_lo[idx] = val;
      else if (idx < 6) box_hi[idx - 3] = val;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic set_box(input logic [31:0] lx, ly, lz, hx, hy, hz);
      write_box(sbpo_pkg::REG_LOW_X, lx);
      write_box(sbpo_pkg::REG_LOW_Y, ly);
      write_box(sbpo_pkg::REG_LOW_Z, lz);
      write_box(sbpo_pkg::REG_HIGH_X, hx);
      write_box(sbpo_pkg::REG_HIGH_Y, hy);
      write_box(sbpo_pkg::REG_HIGH_Z, hz);
   endtask

   task automatic add_sphere(input logic [31:0] x, y, z, input logic [30:0] r);
      sphere_type s;
      s.cx = x;
      s.cy = y;
      s.cz = z;
      s.r = r;
      sphere_q.push_back(s);
   endtask

   task automatic drain;
      wait (sphere_q.size() == 0 && !req_valid && push_q.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coord(int k);
      logic signed [63:0] lo, hi;
      lo = box_lo[k];
      hi = box_hi[k];
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return 32'(lo - $urandom_range(0, 300000));
         2: return 32'(hi + $urandom_range(0, 300000));
         3: return 32'($urandom_range(0, 1) ? lo : hi);
         4: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         5: return 32'($urandom_range(0, 1) ? 64'sd0 : lo + $urandom_range(0, 3));
         default: return 32'(lo + ((hi - lo) * $urandom_range(0, 1000)) / 1000);
      endcase
   endfunction

   function automatic logic [30:0] pick_radius();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 31'h7FFF_FFFF;
         2: return 31'($urandom);
         default: return 31'($urandom_range(0, 1 << 21));
      endcase
   endfunction

   logic [31:0] base, span;

   initial begin
      box_lo = '{default: '0};
      box_hi = '{default: '0};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset box: every centre is outside
      add_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0);
      add_sphere(32'h7FFF_FFFF, 32'h0, 32'h0, 31'd0);
      add_sphere(32'h0, 32'h0, 32'h0, 31'h7FFF_FFFF);
      add_sphere(32'h1, 32'h1, 32'h1, 31'h7FFF_FFFF);
      add_sphere(32'hFFFF_FFFD, 32'h3, 32'h3, 31'd2);
      drain();

      set_box(-32'sd655360, -32'sd655360, -32'sd655360,
              32'sd655360, 32'sd655360, 32'sd655360);
      write_box(3'd6, 32'h1234_5678);
      write_box(3'd7, 32'hFFFF_FFFF);
      add_sphere(32'h0, 32'h0, 32'h0, 31'd100);
      add_sphere(32'd1, 32'd2, -32'sd3, 31'd0);
      add_sphere(32'h0, 32'd5, 32'h0, 31'h7FFF_FFFF);
      add_sphere(32'd655360, 32'h0, 32'h0, 31'd65536);
      add_sphere(-32'sd655360, -32'sd655360, -32'sd655360, 31'd1);
      add_sphere(32'd655361, 32'd655361, 32'd655361, 31'h7FFF_FFFF);
      add_sphere(32'd655363, 32'd0, 32'd655363, 31'd0);
      add_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      add_sphere(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0);
      add_sphere(32'd700000, 32'd1, 32'd1, 31'd131072);
      add_sphere(32'hFFF0_0000, 32'h0, 32'h0, 31'd40000);
      drain();

      // full range box and an inverted box
      set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      add_sphere(32'h8000_0000, 32'h0, 32'h0, 31'd5);
      add_sphere(32'h8000_0001, 32'h7FFF_FFFE, 32'h0, 31'd5);
      add_sphere(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      drain();
      set_box(32'd100000, 32'd100000, 32'd100000, -32'sd100000, -32'sd100000, 32'd0);
      add_sphere(32'h0, 32'h0, 32'h0, 31'd70000);
      add_sphere(32'd100000, -32'sd100000, 32'd50000, 31'd0);
      add_sphere(32'd200000, 32'd200000, -32'sd200000, 31'h7FFF_FFFF);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         idle_mode = ph / 2;
         for (int k = 0; k < 3; k++) begin
            base = $urandom;
            span = (ph == 5) ? $urandom : $urandom_range(0, 1 << 24);
            if ($urandom_range(0, 4) == 0) begin
               write_box(k[2:0], base);
               write_box(k[2:0] + 3'd3, base - span);
            end else begin
               if ($signed(base) > $signed(32'h7FFF_FFFF - span))
                  base = 32'h7FFF_FFFF - span;
               write_box(k[2:0], base);
               write_box(k[2:0] + 3'd3, base + span);
            end
         end
         for (int i = 0; i < 270; i++)
            add_sphere(pick_coord(0), pick_coord(1), pick_coord(2), pick_radius());
         drain();
      end

      if (errors == 0 && push_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
